### rtl/sha256_pkg.sv
// SHA-256 hasher package: payload structs, front/back command struct, round
// constants and round helper functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       ends_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // command from the front (packer) to the back (compressor)
    typedef struct packed {
        logic [511:0] block;
        logic         final_blk;
    } blk_cmd_t;

    typedef enum logic [1:0] {
        FR_BYTES,
        FR_PAD,
        FR_LEN
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_ADD,
        BK_EMIT
    } back_state_t;

    localparam int QueueDepth = 2;
    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenStart = 6'd56;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

endpackage
`default_nettype wire

### rtl/sha256_front.sv
// SHA-256 front: packs message bytes into 512-bit blocks and appends padding.
// Depends on sha256_pkg. Hands complete blocks to the block queue.
`timescale 1ns / 1ps
`default_nettype none
module sha256_front
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_item,
    input  wire logic     push,
    output logic          full,
    output blk_cmd_t      blk,
    output logic          blk_valid,
    input  wire logic     blk_ready
);

    front_state_t state_reg, state_next;
    logic [511:0] block_reg, block_next;
    logic [5:0]   count_reg, count_next;
    logic [63:0]  bits_reg, bits_next;

    logic [511:0] with_byte;
    logic [7:0]   put_val;

    always_comb
    begin
        with_byte = block_reg;
        with_byte[511 - 8 * count_reg -: 8] = put_val;
    end

    always_comb
    begin
        state_next = state_reg;
        block_next = block_reg;
        count_next = count_reg;
        bits_next  = bits_reg;
        blk_valid  = 1'b0;
        blk.block  = with_byte;
        blk.final_blk = 1'b0;
        full       = 1'b1;
        put_val    = in_item.data_byte;
        unique case (state_reg)
            FR_BYTES:
            begin
                // a byte that closes a block needs the queue
                full = in_item.has_byte && (count_reg == 6'd63) && !blk_ready;
                if (push && !full)
                begin
                    if (in_item.has_byte)
                    begin
                        bits_next = bits_reg + 64'd8;
                        blk_valid = (count_reg == 6'd63);
                        block_next = (count_reg == 6'd63) ? '0 : with_byte;
                        count_next = count_reg + 6'd1;
                    end
                    if (in_item.ends_message)
                    begin
                        state_next = FR_PAD;
                    end
                end
            end
            FR_PAD:
            begin
                put_val = PadByte;
                if (count_reg >= LenStart)
                begin
                    // no room for length: flush this block padded with zeros
                    blk_valid = 1'b1;
                    if (blk_ready)
                    begin
                        block_next = '0;
                        count_next = '0;
                        state_next = FR_LEN;
                    end
                end
                else
                begin
                    block_next = with_byte;
                    count_next = count_reg + 6'd1;
                    state_next = FR_LEN;
                end
            end
            FR_LEN:
            begin
                blk.block = {block_reg[511:64], bits_reg};
                blk.final_blk = 1'b1;
                blk_valid = 1'b1;
                if (blk_ready)
                begin
                    block_next = '0;
                    count_next = '0;
                    bits_next  = '0;
                    state_next = FR_BYTES;
                end
            end
            default: state_next = FR_BYTES;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_BYTES;
            block_reg <= '0;
            count_reg <= '0;
            bits_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            block_reg <= block_next;
            count_reg <= count_next;
            bits_reg  <= bits_next;
        end
    end

endmodule
`default_nettype wire

### rtl/sha256_queue.sv
// Two-entry block queue between front and back.
// Depends on sha256_pkg (blk_cmd_t, QueueDepth).
`timescale 1ns / 1ps
`default_nettype none
module sha256_queue
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire blk_cmd_t wr_data,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    output blk_cmd_t      rd_data,
    output logic          rd_valid,
    input  wire logic     rd_ready
);

    localparam int PtrW = $clog2(QueueDepth);

    blk_cmd_t          mem_reg [QueueDepth];
    logic [PtrW-1:0]   wp_reg, rp_reg;
    logic [PtrW:0]     cnt_reg;
    logic              wr_en, rd_en;

    assign wr_ready = (cnt_reg != PtrW'(0) + (PtrW + 1)'(QueueDepth));
    assign rd_valid = (cnt_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == PtrW'(QueueDepth - 1)) ? '0 : wp_reg + PtrW'(1);
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == PtrW'(QueueDepth - 1)) ? '0 : rp_reg + PtrW'(1);
            end
            cnt_reg <= cnt_reg + (PtrW + 1)'(wr_en) - (PtrW + 1)'(rd_en);
        end
    end

endmodule
`default_nettype wire

### rtl/sha256_back.sv
// SHA-256 back: one compression round per cycle, hash update, digest output.
// Depends on sha256_pkg. Takes blocks from the queue, drives the result port.
`timescale 1ns / 1ps
`default_nettype none
module sha256_back
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire blk_cmd_t blk,
    input  wire logic     blk_valid,
    output logic          blk_ready,
    output out_item_t     out_item,
    output logic          empty,
    input  wire logic     pop
);

    back_state_t  state_reg, state_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [5:0]   rnd_reg;
    logic         fin_reg;
    logic [2:0]   idx_reg;

    logic [31:0] t1, t2, wnew;

    assign t1 = v_reg[7] + bsig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + RoundK[rnd_reg] + w_reg[0];
    assign t2 = bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign wnew = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];

    always_comb
    begin
        state_next = state_reg;
        blk_ready  = 1'b0;
        empty      = 1'b1;
        unique case (state_reg)
            BK_IDLE:
            begin
                blk_ready = 1'b1;
                if (blk_valid)
                begin
                    state_next = BK_ROUND;
                end
            end
            BK_ROUND:
            begin
                if (rnd_reg == 6'd63)
                begin
                    state_next = BK_ADD;
                end
            end
            BK_ADD:
            begin
                state_next = fin_reg ? BK_EMIT : BK_IDLE;
            end
            BK_EMIT:
            begin
                empty = 1'b0;
                if (pop && idx_reg == 3'd7)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign out_item.digest_word = h_reg[idx_reg];
    assign out_item.word_index  = idx_reg;
    assign out_item.last_word   = (idx_reg == 3'd7);

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_IDLE && blk_valid)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk.block[511 - 32 * i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
            fin_reg <= blk.final_blk;
        end
        else if (state_reg == BK_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitHash[255 - 32 * i -: 32];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_ROUND)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (state_reg == BK_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (state_reg == BK_EMIT && pop)
            begin
                idx_reg <= idx_reg + 3'd1;
                // drop the digest after the last beat, restart the chain
                if (idx_reg == 3'd7)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= InitHash[255 - 32 * i -: 32];
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

### rtl/sha256_message_hasher_unit.sv
// SHA-256 hasher top level: front packer, block queue, compression back end.
// Depends on sha256_pkg, sha256_front, sha256_queue, sha256_back.
`timescale 1ns / 1ps
`default_nettype none
// A message enters one byte per beat; an item with ends_message set closes it,
// and the eight digest words then leave as eight beats, word 0 first. The
// front takes one item per cycle, but holds full while it pads or writes the
// length, and when a byte that closes a block finds the two-entry block queue
// full. Each 64-byte block takes one load, 64 rounds and one hash add in the
// single round unit of the back end, so sustained input is about one byte per
// cycle. The end item adds one or two final blocks and the eight digest beats.
module sha256_message_hasher_unit
    import sha256_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire in_item_t in_item,
    input  wire logic     push,
    output logic          full,
    output out_item_t     out_item,
    output logic          empty,
    input  wire logic     pop
);

    blk_cmd_t f_blk, b_blk;
    logic     f_valid, f_ready, b_valid, b_ready;

    sha256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .push      (push),
        .full      (full),
        .blk       (f_blk),
        .blk_valid (f_valid),
        .blk_ready (f_ready)
    );

    sha256_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (f_blk),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .rd_data  (b_blk),
        .rd_valid (b_valid),
        .rd_ready (b_ready)
    );

    sha256_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (b_blk),
        .blk_valid (b_valid),
        .blk_ready (b_ready),
        .out_item  (out_item),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
`default_nettype wire

### rtl/sha256_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sha256_checker
    import sha256_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire out_item_t out_item,
    input wire logic      empty,
    input wire logic      pop
);

    // last_word marks exactly the final index
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_item.last_word == (out_item.word_index == 3'd7)))
        else $error("last_word mismatch");

    // index advances by one per beat within a digest
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !out_item.last_word) ##1 !empty
        |-> out_item.word_index == $past(out_item.word_index) + 3'd1)
        else $error("word_index skipped");

    // a stalled beat holds its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("result changed while stalled");

endmodule

bind sha256_message_hasher_unit sha256_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_item (out_item),
    .empty    (empty),
    .pop      (pop)
);
`default_nettype wire

### verif/sha256_message_hasher_checker.sv
// Checker for the SHA-256 message hasher: watches the input and result queues,
// keeps its own running hash and compares each digest beat. Depends on sha256_pkg.
`timescale 1ns / 1ps
module sha256_message_hasher_checker
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  logic      push,
    input  logic      full,
    input  out_item_t out_item,
    input  logic      empty,
    input  logic      pop,
    output int        fail_count,
    output int        pending
);
    localparam logic [31:0] KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] HInit [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] run_hash [8];
    logic [31:0] blk [16];
    logic [5:0]  blk_fill;
    logic [63:0] msg_bits;
    out_item_t   digest_q [$];

    function automatic logic [31:0] rot(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic clear_message();
        for (int i = 0; i < 8; i++) run_hash[i] = HInit[i];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        blk_fill = '0;
        msg_bits = '0;
    endtask

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++) w[t] = blk[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = rot(w[t-15], 7) ^ rot(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rot(w[t-2], 17) ^ rot(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int t = 0; t < 8; t++) v[t] = run_hash[t];
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[t] + w[t];
            t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int t = 0; t < 8; t++) run_hash[t] += v[t];
        for (int i = 0; i < 16; i++) blk[i] = '0;
        blk_fill = '0;
    endtask

    task automatic append_byte(logic [7:0] b);
        blk[blk_fill[5:2]][8*(3 - blk_fill[1:0]) +: 8] = b;
        if (blk_fill == 6'd63) compress();
        else blk_fill++;
    endtask

    task automatic absorb(in_item_t it);
        out_item_t o;
        if (it.has_byte)
        begin
            append_byte(it.data_byte);
            msg_bits += 64'd8;
        end
        if (it.ends_message)
        begin
            append_byte(8'h80);
            if (blk_fill > 6'd56)
                while (blk_fill != 0) append_byte(8'h00);
            blk[14] = msg_bits[63:32];
            blk[15] = msg_bits[31:0];
            compress();
            for (int k = 0; k < 8; k++)
            begin
                o.digest_word = run_hash[k];
                o.word_index = 3'(k);
                o.last_word = (k == 7);
                digest_q.push_back(o);
            end
            clear_message();
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t exp_beat;
        if (!rst_n)
        begin
            clear_message();
            digest_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (digest_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected digest beat %h", out_item);
                    fail_count++;
                end
                else
                begin
                    exp_beat = digest_q.pop_front();
                    if (exp_beat !== out_item)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected word %h idx %0d last %b, got %h %0d %b",
                                     exp_beat.digest_word, exp_beat.word_index,
                                     exp_beat.last_word, out_item.digest_word,
                                     out_item.word_index, out_item.last_word);
                        fail_count++;
                    end
                end
            end
            if (push && !full) absorb(in_item);
        end
        pending = digest_q.size();
    end
endmodule

### verif/sha256_message_hasher_unit_tb.sv
// Testbench top for the SHA-256 message hasher: drives messages under varied
// idling and gives the verdict. Depends on sha256_pkg and the checker module.
`timescale 1ns / 1ps
module sha256_message_hasher_unit_tb;
    import sha256_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    in_item_t  in_item = '0;
    logic      push = 0;
    logic      full;
    out_item_t out_item;
    logic      empty;
    logic      pop = 0;
    int        fail_count;
    int        pending;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_cycles = 0;
    bit        hold_req = 0;
    bit        hold_taken = 0;
    int        cycle_count = 0;

    sha256_message_hasher_unit dut (.*);
    sha256_message_hasher_checker checker_i (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off counted down here
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken <= 1;
            hold_cycles <= 600;
            pop <= 0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            pop <= 0;
        end
        else
            pop <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send(logic [7:0] b, logic hb, logic em);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 0;
            @(negedge clk);
        end
        in_item <= '{data_byte: b, has_byte: hb, ends_message: em};
        push <= 1;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
    endtask

    // random message: mostly bytes, a few flagless items, then the end marker
    task automatic send_message(int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0) send(8'($urandom), 1'b0, 1'b0);
            send(8'($urandom), 1'b1, 1'b0);
        end
        send(8'($urandom), 1'($urandom_range(1)), 1'b1);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: empty message, extremes, padding boundaries
        send(8'hff, 1'b0, 1'b1);
        send(8'h00, 1'b1, 1'b1);
        send(8'hff, 1'b1, 1'b1);
        send(8'h61, 1'b1, 1'b0); send(8'h62, 1'b1, 1'b0); send(8'h63, 1'b0, 1'b1);
        send(8'hff, 1'b0, 1'b0); send(8'h55, 1'b1, 1'b0); send(8'haa, 1'b1, 1'b1);
        send_message(56);
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 54 : 17) : 0;
            stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 54 : 17) : 0;
            if (ph == 0) hold_req = 1;
            for (int m = 0; m < 3; m++)
                send_message((m == 0 && ph == 0) ? 64 : $urandom_range(3));
        end
        push <= 0;
        while (pending > 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
